// ===== rtl/single_wire_humidity_sensor_reader_defines.svh =====
// -----------------------------------------------------------------------------
// single wire humidity sensor reader assertion macros
// shared concurrent check forms used by the reader's rtl
// -----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH

// same-cycle implication, off while in reset
`define SWHSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, off while in reset
`define SWHSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/swhsr_pkg.sv =====
// -----------------------------------------------------------------------------
// swhsr_pkg
// types and constants shared by the single wire humidity sensor reader
// -----------------------------------------------------------------------------
package swhsr_pkg;

    localparam int START_W   = 16;
    localparam int CFG8_W    = 8;
    localparam int ELAPSED_W = 16;
    localparam int BITCNT_W  = 6;
    localparam int FRAME_W   = 40;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // number of data bits in one sensor frame
    localparam logic [BITCNT_W-1:0] FRAME_BITS = 6'd40;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LOW     = 2'd0,
        CFG_RELEASE_HIGH  = 2'd1,
        CFG_TIMEOUT       = 2'd2,
        CFG_BIT_THRESHOLD = 2'd3
    } t_cfg_index;

    // read sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_LOW,
        PH_RELEASE,
        PH_WAIT_RESP,
        PH_RESP_LOW,
        PH_RESP_HIGH,
        PH_BIT_LOW,
        PH_BIT_HIGH
    } t_phase;

    typedef struct packed {
        logic command;
        logic pin_level;
    } t_in_item;

    typedef struct packed {
        logic              drive_enable;
        logic              drive_level;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        status;
        logic              valid_res;
        logic [BYTE_W-1:0] humidity;
        logic [BYTE_W-1:0] temperature;
    } t_out_item;

    typedef struct packed {
        logic [START_W-1:0] start_low_us;
        logic [CFG8_W-1:0]  release_high_us;
        logic [CFG8_W-1:0]  timeout_us;
        logic [CFG8_W-1:0]  bit_threshold_us;
    } t_cfg;

endpackage

// ===== rtl/swhsr_core.sv =====
// -----------------------------------------------------------------------------
// swhsr_core
// read sequencer: holds the read state and works out one beat's result
// -----------------------------------------------------------------------------
`include "single_wire_humidity_sensor_reader_defines.svh"

module swhsr_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  swhsr_pkg::t_in_item  i_item,
    input  swhsr_pkg::t_cfg      i_cfg,
    output swhsr_pkg::t_out_item o_result
);
    import swhsr_pkg::*;

    t_phase               r_phase, n_phase;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [BITCNT_W-1:0]  r_bits, n_bits;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic [BYTE_W-1:0]    r_hum, n_hum;
    logic [BYTE_W-1:0]    r_temp, n_temp;
    logic                 r_valid, n_valid;

    logic                 done;
    logic                 fail;
    logic [1:0]           status;
    logic                 bit_one;
    logic                 held_timeout;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [BITCNT_W-1:0]  bits_inc;
    logic [FRAME_W-1:0]   shifted;
    logic [BYTE_W-1:0]    sum;
    logic                 held;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_bits    <= '0;
            r_frame   <= '0;
            r_hum     <= '0;
            r_temp    <= '0;
            r_valid   <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_bits    <= n_bits;
            r_frame   <= n_frame;
            r_hum     <= n_hum;
            r_temp    <= n_temp;
            r_valid   <= n_valid;
        end
    end

    // next state and result for the beat in hand
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_bits    = r_bits;
        n_frame   = r_frame;
        n_hum     = r_hum;
        n_temp    = r_temp;
        n_valid   = r_valid;
        done      = 1'b0;
        fail      = 1'b0;
        status    = STATUS_OK;
        held      = 1'b0;

        bit_one      = r_elapsed > ELAPSED_W'(i_cfg.bit_threshold_us);
        held_timeout = r_elapsed > ELAPSED_W'(i_cfg.timeout_us);
        elapsed_inc  = r_elapsed + ELAPSED_W'(1);
        bits_inc     = r_bits + BITCNT_W'(1);
        shifted      = {r_frame[FRAME_W-2:0], bit_one};
        sum          = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];

        if (i_item.command) begin
            // start only from idle, otherwise the command is ignored
            if (r_phase == PH_IDLE) begin
                n_phase   = PH_START_LOW;
                n_elapsed = '0;
                n_bits    = '0;
                n_frame   = '0;
            end
        end else begin
            case (r_phase)
                PH_START_LOW, PH_RELEASE: begin
                    n_elapsed = elapsed_inc;
                end
                PH_WAIT_RESP, PH_RESP_HIGH: begin
                    if (i_item.pin_level) begin
                        held = 1'b1;
                    end else begin
                        n_phase   = (r_phase == PH_WAIT_RESP) ? PH_RESP_LOW : PH_BIT_LOW;
                        n_elapsed = ELAPSED_W'(1);
                    end
                end
                PH_RESP_LOW, PH_BIT_LOW: begin
                    if (!i_item.pin_level) begin
                        held = 1'b1;
                    end else begin
                        n_phase   = (r_phase == PH_RESP_LOW) ? PH_RESP_HIGH : PH_BIT_HIGH;
                        n_elapsed = ELAPSED_W'(1);
                    end
                end
                PH_BIT_HIGH: begin
                    if (i_item.pin_level) begin
                        held = 1'b1;
                    end else begin
                        n_frame = shifted;
                        n_bits  = bits_inc;
                        if (bits_inc >= FRAME_BITS) begin
                            // last bit in: check the frame sum
                            done      = 1'b1;
                            n_phase   = PH_IDLE;
                            n_elapsed = '0;
                            if (sum != shifted[7:0]) begin
                                n_valid = 1'b0;
                                status  = STATUS_CHECKSUM;
                            end else begin
                                n_hum   = shifted[39:32];
                                n_temp  = shifted[23:16];
                                n_valid = 1'b1;
                            end
                        end else begin
                            n_phase   = PH_BIT_LOW;
                            n_elapsed = ELAPSED_W'(1);
                        end
                    end
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // awaited level still present
            if (held) begin
                if (held_timeout) begin
                    fail = 1'b1;
                end else begin
                    n_elapsed = elapsed_inc;
                end
            end

            if (fail) begin
                n_phase   = PH_IDLE;
                n_elapsed = '0;
                n_valid   = 1'b0;
                done      = 1'b1;
                status    = STATUS_TIMEOUT;
            end
        end

        // drive phases end at once when their length is reached
        if (n_phase == PH_START_LOW && n_elapsed >= i_cfg.start_low_us) begin
            n_phase   = PH_RELEASE;
            n_elapsed = '0;
        end
        if (n_phase == PH_RELEASE && n_elapsed >= ELAPSED_W'(i_cfg.release_high_us)) begin
            n_phase   = PH_WAIT_RESP;
            n_elapsed = '0;
        end

        o_result.drive_enable = (n_phase == PH_START_LOW) || (n_phase == PH_RELEASE);
        o_result.drive_level  = (n_phase == PH_RELEASE);
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.done_res     = done;
        o_result.status       = done ? status : STATUS_OK;
        o_result.valid_res    = n_valid;
        o_result.humidity     = n_hum;
        o_result.temperature  = n_temp;
    end

    // checks
    `SWHSR_ASSERT_IMP(a_drive_busy, i_clk, i_rst_n, o_result.drive_enable, o_result.busy_res)
    `SWHSR_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_result.done_res, !o_result.busy_res)
    `SWHSR_ASSERT_IMP(a_ok_valid, i_clk, i_rst_n, o_result.done_res && o_result.status == STATUS_OK, o_result.valid_res)

endmodule

// ===== rtl/single_wire_humidity_sensor_reader.sv =====
// -----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Reads a single-wire humidity and temperature sensor. Each input beat is a
// one microsecond tick with the sampled line level, or a start command, and
// gives exactly one result beat. The block takes one beat per clock cycle
// while the input is not stalled; a beat passes an input register and the
// sequencer update into the result register, and leaves the input register
// only when the result register is empty or not stalled. The configuration
// registers are always ready and are to be written only while no read is running.
// -----------------------------------------------------------------------------
`include "single_wire_humidity_sensor_reader_defines.svh"

module single_wire_humidity_sensor_reader (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  swhsr_pkg::t_in_item                    i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output swhsr_pkg::t_out_item                   o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [swhsr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [swhsr_pkg::CFG_DAT_W-1:0]        i_cfg_data
);
    import swhsr_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    t_out_item result;
    logic      advance;
    logic      take;

    // handshake control
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign take        = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_us     <= 16'd18000;
            r_cfg.release_high_us  <= 8'd40;
            r_cfg.timeout_us       <= 8'd80;
            r_cfg.bit_threshold_us <= 8'd40;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_LOW:     r_cfg.start_low_us     <= i_cfg_data;
                CFG_RELEASE_HIGH:  r_cfg.release_high_us  <= i_cfg_data[CFG8_W-1:0];
                CFG_TIMEOUT:       r_cfg.timeout_us       <= i_cfg_data[CFG8_W-1:0];
                CFG_BIT_THRESHOLD: r_cfg.bit_threshold_us <= i_cfg_data[CFG8_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_item <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    // read sequencer
    swhsr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // checks
    `SWHSR_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, advance, r_out_valid)
    `SWHSR_ASSERT_NEXT(a_beat_kept, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)
    `SWHSR_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_out_valid && i_out_stall)

endmodule
